@@ hw/rtl/hfat_pkg.sv @@
// Shared types, codes and character tables for the hands-free AT handshake parser.
// No dependencies; used by every module of the block.
package hfat_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;

   localparam logic [1:0] OP_DATA  = 2'd0;
   localparam logic [1:0] OP_OPEN  = 2'd1;
   localparam logic [1:0] OP_CLOSE = 2'd2;

   localparam logic [2:0] HS_INIT   = 3'd0;
   localparam logic [2:0] HS_FEAT   = 3'd1;
   localparam logic [2:0] HS_LIST   = 3'd2;
   localparam logic [2:0] HS_VALUES = 3'd3;
   localparam logic [2:0] HS_OK     = 3'd4;
   localparam logic [2:0] HS_ERROR  = 3'd5;

   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_FEAT  = 3'd1;
   localparam logic [2:0] CMD_TEST  = 3'd2;
   localparam logic [2:0] CMD_READ  = 3'd3;
   localparam logic [2:0] CMD_EVENT = 3'd4;

   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_OK    = 3'd1;
   localparam logic [2:0] CLS_FEAT  = 3'd2;
   localparam logic [2:0] CLS_IND   = 3'd3;
   localparam logic [2:0] CLS_EVT   = 3'd4;
   localparam logic [2:0] CLS_ERR   = 3'd5;
   localparam logic [2:0] CLS_UNREC = 3'd6;
   localparam logic [2:0] CLS_PLUS  = 3'd7;

   localparam logic [1:0] TW_NONE  = 2'd0;
   localparam logic [1:0] TW_KIND  = 2'd1;
   localparam logic [1:0] TW_VALUE = 2'd2;

   localparam logic [3:0] KIND_UNKNOWN = 4'd8;

   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_LF = 8'd10;

   localparam logic [39:0] PFX_BRSF  = "+BRSF";
   localparam logic [39:0] PFX_CIND  = "+CIND";
   localparam logic [39:0] PFX_CIEV  = "+CIEV";
   localparam logic [39:0] PFX_ERROR = "ERROR";

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic [7:0] open_status;
   } req_type;

   typedef struct packed {
      logic [2:0] link_state;
      logic [2:0] send_command;
      logic [2:0] line_kind;
      logic [1:0] table_write;
      logic [3:0] slot_number;
      logic [3:0] kind_written;
      logic [7:0] value_written;
   } rsp_type;

   // Request after decoding in the front part.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] data_byte;
      logic       open_ok;
      logic       is_cr;
      logic       is_lf;
   } item_type;

   typedef struct packed {
      logic [2:0] prefix_position;
      logic [2:0] line_class;
      logic [2:0] list_scan;
      logic [1:0] value_scan;
      logic [4:0] group_counter;
      logic [7:0] name_candidates;
      logic [3:0] name_position;
      logic [7:0] value_accumulator;
   } line_type;

   typedef struct packed {
      logic [1:0] tw;
      logic [3:0] slot;
      logic [3:0] kind;
      logic [7:0] val;
   } wr_type;

   function automatic logic [3:0] name_len(input logic [2:0] idx);
      logic [3:0] len;
      unique case (idx)
         3'd0: len = 4'd7;
         3'd1: len = 4'd4;
         3'd2: len = 4'd9;
         3'd3: len = 4'd10;
         3'd4: len = 4'd8;
         3'd5: len = 4'd6;
         3'd6: len = 4'd4;
         default: len = 4'd7;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] name_kind(input logic [2:0] idx);
      logic [3:0] k;
      unique case (idx)
         3'd0: k = 4'd1;
         3'd1: k = 4'd2;
         3'd2: k = 4'd3;
         3'd3: k = 4'd3;
         3'd4: k = 4'd4;
         3'd5: k = 4'd5;
         3'd6: k = 4'd6;
         default: k = 4'd7;
      endcase
      return k;
   endfunction

   // Character at position pos of indicator name idx (pos below the name length).
   function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [3:0] pos);
      logic [79:0] word;
      logic [3:0]  sh;
      unique case (idx)
         3'd0: word = 80'("service");
         3'd1: word = 80'("call");
         3'd2: word = 80'("callsetup");
         3'd3: word = 80'("call\137setup");
         3'd4: word = 80'("callheld");
         3'd5: word = 80'("signal");
         3'd6: word = 80'("roam");
         default: word = 80'("battchg");
      endcase
      sh = 4'(name_len(idx) - 4'd1 - pos);
      return word[{sh, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] pfx_char(input logic [39:0] word, input logic [2:0] pos);
      logic [2:0] sh;
      sh = 3'(3'd4 - pos);
      return word[{sh, 3'b000} +: 8];
   endfunction

endpackage

@@ hw/rtl/hfat_front.sv @@
// Front part: decodes an incoming request into the queue item format.
// Depends on hfat_pkg.
module hfat_front (
   input  hfat_pkg::req_type  req_data,
   output hfat_pkg::item_type item
);

   always_comb begin
      item.opcode    = req_data.opcode;
      item.data_byte = req_data.data_byte;
      item.open_ok   = (req_data.open_status == 8'd0);
      item.is_cr     = (req_data.data_byte == hfat_pkg::CH_CR);
      item.is_lf     = (req_data.data_byte == hfat_pkg::CH_LF);
   end

endmodule

@@ hw/rtl/hfat_queue.sv @@
// Two-entry queue between the front and back parts.
// Depends on hfat_pkg.
module hfat_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hfat_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output hfat_pkg::item_type pop_item
);

   hfat_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/hfat_back.sv @@
// Back part: line parser, handshake state, indicator tables and result register.
// Depends on hfat_pkg.
module hfat_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  hfat_pkg::item_type item,
   output logic               item_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hfat_pkg::rsp_type  rsp_data
);

   typedef struct packed {
      hfat_pkg::line_type ln;
      hfat_pkg::wr_type   wr;
   } feed_res_type;

   logic [2:0]         hs_ff, hs_in;
   hfat_pkg::line_type line_ff, line_in;
   logic               cs_ff, cs_in;
   logic               out_valid_ff, out_valid_in;
   hfat_pkg::rsp_type  out_ff, out_in;
   logic [3:0]         kind_table_ff  [hfat_pkg::SLOT_COUNT];
   logic [7:0]         value_table_ff [hfat_pkg::SLOT_COUNT];

   function automatic logic [4:0] group_inc(input logic [4:0] g);
      return (g < 5'd31) ? 5'(g + 5'd1) : g;
   endfunction

   function automatic hfat_pkg::line_type name_match(input hfat_pkg::line_type l,
                                                      input logic [7:0] c);
      hfat_pkg::line_type r;
      r = l;
      for (int i = 0; i < 8; i++) begin
         if (l.name_candidates[i] &&
             ((l.name_position >= hfat_pkg::name_len(3'(i))) ||
              (hfat_pkg::name_char(3'(i), l.name_position) != c))) begin
            r.name_candidates[i] = 1'b0;
         end
      end
      if (l.name_position < 4'd15) r.name_position = 4'(l.name_position + 4'd1);
      return r;
   endfunction

   function automatic hfat_pkg::wr_type store_value(input hfat_pkg::line_type l);
      hfat_pkg::wr_type w;
      w = '0;
      if (l.group_counter < 5'(hfat_pkg::SLOT_COUNT)) begin
         w.tw   = hfat_pkg::TW_VALUE;
         w.slot = l.group_counter[hfat_pkg::SLOT_W-1:0];
         w.val  = l.value_accumulator;
      end
      return w;
   endfunction

   function automatic feed_res_type feed(input hfat_pkg::line_type l, input logic [2:0] hs,
                                         input logic [7:0] c);
      feed_res_type r;
      logic [2:0]   p, k;
      logic         dig;
      logic [11:0]  v;
      logic [3:0]   kd;
      r.ln = l;
      r.wr = '0;
      p    = l.prefix_position;
      k    = l.line_class;
      dig  = (c >= "0") && (c <= "9");
      v    = 12'(l.value_accumulator) * 12'd10 + 12'(c - 8'd48);
      kd   = hfat_pkg::KIND_UNKNOWN;
      for (int i = 7; i >= 0; i--) begin
         if (l.name_candidates[i]) kd = hfat_pkg::name_kind(3'(i));
      end
      if (p < 3'd5) begin
         // Prefix classification, one character at a time.
         if (p == 3'd0) begin
            k = (c == "+") ? hfat_pkg::CLS_PLUS : (c == "O") ? hfat_pkg::CLS_OK :
                (c == "E") ? hfat_pkg::CLS_ERR : hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_PLUS) begin
            k = (c == "B") ? hfat_pkg::CLS_FEAT : (c == "C") ? hfat_pkg::CLS_IND :
                hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_OK) begin
            if (p == 3'd1 && c != "K") k = hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_FEAT) begin
            if (c != hfat_pkg::pfx_char(hfat_pkg::PFX_BRSF, p)) k = hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_ERR) begin
            if (c != hfat_pkg::pfx_char(hfat_pkg::PFX_ERROR, p)) k = hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_IND) begin
            if (p == 3'd3 && c == "E") k = hfat_pkg::CLS_EVT;
            else if (c != hfat_pkg::pfx_char(hfat_pkg::PFX_CIND, p)) k = hfat_pkg::CLS_UNREC;
         end else if (k == hfat_pkg::CLS_EVT) begin
            if (c != hfat_pkg::pfx_char(hfat_pkg::PFX_CIEV, p)) k = hfat_pkg::CLS_UNREC;
         end
         r.ln.line_class      = k;
         r.ln.prefix_position = 3'(p + 3'd1);
      end else if (k == hfat_pkg::CLS_IND && hs == hfat_pkg::HS_LIST) begin
         unique case (l.list_scan)
            3'd0: begin
               if (c == "(") begin
                  r.ln.group_counter = group_inc(l.group_counter);
                  r.ln.list_scan     = 3'd1;
               end
            end
            3'd1: if (c == "\"") r.ln.list_scan = 3'd2;
            3'd2: begin
               r.ln.name_candidates = 8'hFF;
               r.ln.name_position   = 4'd0;
               r.ln                 = name_match(r.ln, c);
               r.ln.list_scan       = 3'd3;
            end
            3'd3: begin
               if (c == "\"") begin
                  for (int i = 0; i < 8; i++) begin
                     if (hfat_pkg::name_len(3'(i)) != l.name_position) begin
                        r.ln.name_candidates[i] = 1'b0;
                     end
                  end
                  r.ln.list_scan = 3'd4;
               end else begin
                  r.ln = name_match(l, c);
               end
            end
            3'd4: if (c == "(") r.ln.list_scan = 3'd5;
            3'd5: r.ln.list_scan = 3'd6;
            3'd6: if (c == ")") r.ln.list_scan = 3'd7;
            default: begin
               // The kind is written on the character after the closing parenthesis.
               if (l.group_counter < 5'(hfat_pkg::SLOT_COUNT)) begin
                  r.wr.tw   = hfat_pkg::TW_KIND;
                  r.wr.slot = l.group_counter[hfat_pkg::SLOT_W-1:0];
                  r.wr.kind = kd;
               end
               r.ln.list_scan = 3'd0;
            end
         endcase
      end else if (k == hfat_pkg::CLS_IND && hs == hfat_pkg::HS_VALUES) begin
         unique case (l.value_scan)
            2'd0: begin
               if (c == " ") begin
                  r.ln.group_counter = group_inc(l.group_counter);
                  r.ln.value_scan    = 2'd1;
               end
            end
            2'd1: begin
               r.ln.value_accumulator = dig ? 8'(c - 8'd48) : 8'd0;
               r.ln.value_scan        = dig ? 2'd2 : 2'd3;
            end
            2'd2: begin
               if (c == ",") begin
                  r.wr               = store_value(l);
                  r.ln.group_counter = group_inc(l.group_counter);
                  r.ln.value_scan    = 2'd1;
               end else if (dig) begin
                  r.ln.value_accumulator = (v > 12'd255) ? 8'd255 : v[7:0];
               end else begin
                  r.ln.value_scan = 2'd3;
               end
            end
            default: begin
               if (c == ",") begin
                  r.wr               = store_value(l);
                  r.ln.group_counter = group_inc(l.group_counter);
                  r.ln.value_scan    = 2'd1;
               end
            end
         endcase
      end
      return r;
   endfunction

   logic advance;
   assign advance   = !out_valid_ff || rsp_ready;
   assign item_pop  = item_valid && advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      hfat_pkg::line_type ln;
      hfat_pkg::wr_type   wr;
      feed_res_type       fr;
      logic [2:0]         hs, send, kind;
      logic               cs, done;
      ln   = line_ff;
      hs   = hs_ff;
      cs   = cs_ff;
      wr   = '0;
      send = hfat_pkg::CMD_NONE;
      kind = hfat_pkg::CLS_NONE;
      done = 1'b0;
      fr   = '0;
      unique case (item.opcode)
         hfat_pkg::OP_DATA: begin
            if (cs && item.is_lf) begin
               // CR LF closes the line.
               cs   = 1'b0;
               done = ((ln.line_class == hfat_pkg::CLS_OK) && (ln.prefix_position >= 3'd2)) ||
                      ((ln.line_class >= hfat_pkg::CLS_FEAT) &&
                       (ln.line_class <= hfat_pkg::CLS_ERR) && (ln.prefix_position == 3'd5));
               if (ln.prefix_position != 3'd0 && done) begin
                  kind = ln.line_class;
                  if (hs == hfat_pkg::HS_FEAT && kind == hfat_pkg::CLS_FEAT) begin
                     hs   = hfat_pkg::HS_LIST;
                     send = hfat_pkg::CMD_TEST;
                  end else if (hs == hfat_pkg::HS_LIST && kind == hfat_pkg::CLS_IND) begin
                     hs   = hfat_pkg::HS_VALUES;
                     send = hfat_pkg::CMD_READ;
                  end else if (hs == hfat_pkg::HS_VALUES && kind == hfat_pkg::CLS_IND) begin
                     if (ln.value_scan >= 2'd2) wr = store_value(ln);
                     hs   = hfat_pkg::HS_OK;
                     send = hfat_pkg::CMD_EVENT;
                  end else if (kind != hfat_pkg::CLS_OK) begin
                     hs = hfat_pkg::HS_ERROR;
                  end
               end
               ln = '0;
            end else begin
               if (cs) begin
                  // A CR not followed by LF is an ordinary character.
                  fr = feed(ln, hs, hfat_pkg::CH_CR);
                  ln = fr.ln;
                  wr = fr.wr;
               end
               cs = item.is_cr;
               if (!item.is_cr) begin
                  fr = feed(ln, hs, item.data_byte);
                  ln = fr.ln;
                  if (fr.wr.tw != hfat_pkg::TW_NONE) wr = fr.wr;
               end
            end
         end
         hfat_pkg::OP_OPEN: begin
            if (item.open_ok) begin
               if (hs == hfat_pkg::HS_INIT) begin
                  hs   = hfat_pkg::HS_FEAT;
                  send = hfat_pkg::CMD_FEAT;
               end else begin
                  hs = hfat_pkg::HS_ERROR;
               end
            end
         end
         hfat_pkg::OP_CLOSE: begin
            hs = hfat_pkg::HS_INIT;
            ln = '0;
            cs = 1'b0;
         end
         default: ;
      endcase
      hs_in                = hs;
      line_in              = ln;
      cs_in                = cs;
      out_in.link_state    = hs;
      out_in.send_command  = send;
      out_in.line_kind     = kind;
      out_in.table_write   = wr.tw;
      out_in.slot_number   = wr.slot;
      out_in.kind_written  = wr.kind;
      out_in.value_written = wr.val;
      out_valid_in         = item_pop ? 1'b1 : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff        <= hfat_pkg::HS_INIT;
         line_ff      <= '0;
         cs_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < hfat_pkg::SLOT_COUNT; i++) begin
            kind_table_ff[i]  <= 4'd0;
            value_table_ff[i] <= 8'd0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         if (item_pop) begin
            hs_ff   <= hs_in;
            line_ff <= line_in;
            cs_ff   <= cs_in;
            if (out_in.table_write == hfat_pkg::TW_KIND) begin
               kind_table_ff[out_in.slot_number] <= out_in.kind_written;
            end
            if (out_in.table_write == hfat_pkg::TW_VALUE) begin
               value_table_ff[out_in.slot_number] <= out_in.value_written;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         out_ff <= out_in;
      end
   end

endmodule

@@ hw/rtl/hands_free_at_handshake_parser.sv @@
// Hands-free AT response parser, top level. A request accepted into a queue entry
// moves on to the result register, and from there it is shown on the response port.
// Throughput: one request per cycle, set by the parser step in the back part, while rsp_ready does not stall it.
// Reset (synchronous, active high) returns the handshake to initializing, empties the
// queue and result register, and clears both indicator tables at once.
// Depends on hfat_pkg, hfat_front, hfat_queue and hfat_back.
module hands_free_at_handshake_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hfat_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hfat_pkg::rsp_type rsp_data
);

   hfat_pkg::item_type front_item;
   hfat_pkg::item_type back_item;
   logic               q_full, q_not_empty, q_pop;

   assign req_ready = !q_full;

   hfat_front u_front (
      .req_data (req_data),
      .item     (front_item)
   );

   hfat_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (back_item)
   );

   hfat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_not_empty),
      .item       (back_item),
      .item_pop   (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
